// ===== sv/ltr_pkg.sv =====
// Shared types, codes and constants for the LCD text frame renderer.
package ltr_pkg;

    localparam int COLUMNS_DEF       = 128;
    localparam int GLYPH_BYTES_DEF   = 25;
    localparam int GLYPH_COLUMNS_DEF = 12;
    localparam int FONT_DEPTH_DEF    = 4096;

    localparam int PAGES     = 4;
    localparam int CMD_SLOTS = 3;
    localparam int QDEPTH    = 2;

    localparam logic [7:0] FIRST_SYM  = 8'd32;
    localparam logic [7:0] LAST_SYM   = 8'd126;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;

    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_DRAW  = 3'd1;
    localparam logic [2:0] MODE_HOME  = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DRAW,
        OP_HOME,
        OP_CLEAR,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_DRAW,
        ST_DRAW_END,
        ST_TICK_DATA
    } st_t;

    typedef struct packed {
        op_t        op;
        logic [11:0] font_addr;
        logic [7:0]  font_byte;
        logic        text_line;
        logic [7:0]  symbol;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic init;
    } bk_stat_t;

endpackage

// ===== sv/ltr_front.sv =====
// Front end: takes commands, classifies them and queues them for the back end.
module ltr_front #(
    parameter int FONT_DEPTH = ltr_pkg::FONT_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        mode,
    input  logic [11:0]       font_addr,
    input  logic [7:0]        font_byte,
    input  logic              text_line,
    input  logic [7:0]        symbol,
    output logic              busy,
    input  ltr_pkg::bk_stat_t stat,
    output ltr_pkg::q_head_t  head
);

    localparam int QA_W = (ltr_pkg::QDEPTH > 1) ? $clog2(ltr_pkg::QDEPTH) : 1;
    localparam int QC_W = $clog2(ltr_pkg::QDEPTH + 1);

    ltr_pkg::cmd_t q_mem [ltr_pkg::QDEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;

    ltr_pkg::op_t op;
    logic         keep;
    logic         push;
    logic         pop;

    always_comb
    begin
        op   = ltr_pkg::OP_TICK;
        keep = 1'b0;
        unique case (mode)
            ltr_pkg::MODE_LOAD:
            begin
                op   = ltr_pkg::OP_LOAD;
                keep = int'(font_addr) < FONT_DEPTH;
            end
            ltr_pkg::MODE_DRAW:
            begin
                op   = ltr_pkg::OP_DRAW;
                keep = (symbol >= ltr_pkg::FIRST_SYM) && (symbol <= ltr_pkg::LAST_SYM);
            end
            ltr_pkg::MODE_HOME:
            begin
                op   = ltr_pkg::OP_HOME;
                keep = 1'b1;
            end
            ltr_pkg::MODE_CLEAR:
            begin
                op   = ltr_pkg::OP_CLEAR;
                keep = 1'b1;
            end
            ltr_pkg::MODE_TICK:
            begin
                op   = ltr_pkg::OP_TICK;
                keep = 1'b1;
            end
            default:
            begin
                op   = ltr_pkg::OP_TICK;
                keep = 1'b0;
            end
        endcase
    end

    assign busy = (count_reg == QC_W'(ltr_pkg::QDEPTH)) || stat.init;
    assign push = start && !busy && keep;
    assign pop  = stat.pop;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(ltr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(ltr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{op: op, font_addr: font_addr, font_byte: font_byte,
                                   text_line: text_line, symbol: symbol};
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_mem[rd_ptr_reg];

endmodule

// ===== sv/ltr_back.sv =====
// Back end: font and frame stores, glyph copy, frame clearing and refresh streaming.
module ltr_back #(
    parameter int COLUMNS       = ltr_pkg::COLUMNS_DEF,
    parameter int GLYPH_BYTES   = ltr_pkg::GLYPH_BYTES_DEF,
    parameter int GLYPH_COLUMNS = ltr_pkg::GLYPH_COLUMNS_DEF,
    parameter int FONT_DEPTH    = ltr_pkg::FONT_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ltr_pkg::q_head_t  head,
    output ltr_pkg::bk_stat_t stat,
    output logic              strobe,
    output logic [7:0]        out_byte,
    output logic              is_command,
    output logic              frame_last
);

    localparam int FR_DEPTH  = ltr_pkg::PAGES * COLUMNS;
    localparam int FR_AW     = $clog2(FR_DEPTH);
    localparam int FA_W      = $clog2(FONT_DEPTH);
    localparam int RD_W      = $clog2(GLYPH_BYTES * 94 + 2 * GLYPH_COLUMNS + 1);
    localparam int SL_W      = $clog2(COLUMNS + ltr_pkg::CMD_SLOTS);
    localparam int CNT_W     = FR_AW;
    localparam int DRAW_LAST = 2 * GLYPH_COLUMNS;

    // storage
    logic [7:0] font_mem [FONT_DEPTH];
    logic [7:0] frame_mem [FR_DEPTH];
    logic [7:0] font_rd_reg;
    logic [7:0] fr_rd_reg;

    logic            font_we;
    logic [FA_W-1:0] font_wa;
    logic [FA_W-1:0] font_ra;
    logic             fr_we;
    logic [FR_AW-1:0] fr_wa;
    logic [7:0]       fr_wd;
    logic [FR_AW-1:0] fr_ra;

    // control
    ltr_pkg::st_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             active_reg, active_next;
    logic [1:0]       page_reg, page_next;
    logic [SL_W-1:0]  slot_reg, slot_next;
    logic [7:0]       top_reg, top_next;
    logic [7:0]       bot_reg, bot_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             strobe_reg, strobe_next;

    // payload
    logic [RD_W-1:0]  base_reg, base_next;
    logic [7:0]       cur_reg, cur_next;
    logic             line_reg, line_next;
    logic [7:0]       width_reg, width_next;
    logic [CNT_W-1:0] rd_j_reg, rd_j_next;
    logic             oob_reg, oob_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             is_cmd_reg, is_cmd_next;
    logic             last_reg, last_next;
    logic             last_pend_reg, last_pend_next;

    logic             pop;
    logic             sweep_end;
    logic             slot_end;
    logic             tick_last;
    logic [RD_W-1:0]  raddr;
    logic [7:0]       glyph_byte;
    logic [CNT_W-1:0] col_idx;
    logic [8:0]       col;
    logic [1:0]       wr_page;
    logic [8:0]       cur_sum;

    assign sweep_end = (cnt_reg == CNT_W'(FR_DEPTH - 1));
    assign slot_end  = (slot_reg == SL_W'(COLUMNS + ltr_pkg::CMD_SLOTS - 1));
    assign tick_last = slot_end && (page_reg == 2'(ltr_pkg::PAGES - 1));
    assign raddr     = base_reg + RD_W'(cnt_reg);

    // glyph data arriving in the cycle after its font read
    assign glyph_byte = oob_reg ? 8'd0 : font_rd_reg;
    assign col_idx    = (rd_j_reg - 1'b1) >> 1;
    assign col        = {1'b0, cur_reg} + 9'(col_idx);
    assign wr_page    = {line_reg, ~rd_j_reg[0]};
    assign cur_sum    = {1'b0, cur_reg} + {1'b0, width_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ltr_pkg::ST_INIT,
            ltr_pkg::ST_CLEAR:
            begin
                if (sweep_end)
                begin
                    state_next = ltr_pkg::ST_IDLE;
                end
            end
            ltr_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.cmd.op)
                        ltr_pkg::OP_CLEAR: state_next = ltr_pkg::ST_CLEAR;
                        ltr_pkg::OP_DRAW:  state_next = ltr_pkg::ST_DRAW;
                        ltr_pkg::OP_TICK:
                        begin
                            if (active_reg && (slot_reg >= SL_W'(ltr_pkg::CMD_SLOTS)))
                            begin
                                state_next = ltr_pkg::ST_TICK_DATA;
                            end
                        end
                        default: state_next = ltr_pkg::ST_IDLE;
                    endcase
                end
            end
            ltr_pkg::ST_DRAW:
            begin
                if (cnt_reg == CNT_W'(DRAW_LAST))
                begin
                    state_next = ltr_pkg::ST_DRAW_END;
                end
            end
            ltr_pkg::ST_DRAW_END:  state_next = ltr_pkg::ST_IDLE;
            ltr_pkg::ST_TICK_DATA: state_next = ltr_pkg::ST_IDLE;
            default:               state_next = ltr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        font_we        = 1'b0;
        font_wa        = FA_W'(head.cmd.font_addr);
        font_ra        = FA_W'(raddr);
        fr_we          = 1'b0;
        fr_wa          = cnt_reg;
        fr_wd          = 8'd0;
        fr_ra          = FR_AW'(int'(page_reg) * COLUMNS
                                + int'(slot_reg) - ltr_pkg::CMD_SLOTS);
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        page_next      = page_reg;
        slot_next      = slot_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        rd_vld_next    = 1'b0;
        strobe_next    = 1'b0;
        base_next      = base_reg;
        cur_next       = cur_reg;
        line_next      = line_reg;
        width_next     = width_reg;
        rd_j_next      = cnt_reg;
        oob_next       = int'(raddr) >= FONT_DEPTH;
        out_byte_next  = out_byte_reg;
        is_cmd_next    = is_cmd_reg;
        last_next      = last_reg;
        last_pend_next = last_pend_reg;

        unique case (state_reg) inside
            ltr_pkg::ST_INIT,
            ltr_pkg::ST_CLEAR:
            begin
                fr_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ltr_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.cmd.op) inside
                        ltr_pkg::OP_LOAD:
                        begin
                            font_we = 1'b1;
                        end
                        ltr_pkg::OP_HOME,
                        ltr_pkg::OP_CLEAR:
                        begin
                            if (head.cmd.op == ltr_pkg::OP_HOME)
                            begin
                                top_next = 8'd0;
                                bot_next = 8'd0;
                            end
                            active_next = 1'b1;
                            page_next   = 2'd0;
                            slot_next   = '0;
                            cnt_next    = '0;
                        end
                        ltr_pkg::OP_DRAW:
                        begin
                            base_next = RD_W'(GLYPH_BYTES)
                                        * RD_W'(head.cmd.symbol - ltr_pkg::FIRST_SYM);
                            cur_next  = head.cmd.text_line ? bot_reg : top_reg;
                            line_next = head.cmd.text_line;
                            cnt_next  = '0;
                        end
                        ltr_pkg::OP_TICK:
                        begin
                            if (active_reg)
                            begin
                                if (tick_last)
                                begin
                                    active_next = 1'b0;
                                    page_next   = 2'd0;
                                    slot_next   = '0;
                                end
                                else if (slot_end)
                                begin
                                    page_next = page_reg + 1'b1;
                                    slot_next = '0;
                                end
                                else
                                begin
                                    slot_next = slot_reg + 1'b1;
                                end
                                if (slot_reg < SL_W'(ltr_pkg::CMD_SLOTS))
                                begin
                                    strobe_next = 1'b1;
                                    is_cmd_next = 1'b1;
                                    last_next   = 1'b0;
                                    if (slot_reg == '0)
                                    begin
                                        out_byte_next = ltr_pkg::CMD_COL_LO;
                                    end
                                    else if (slot_reg == SL_W'(1))
                                    begin
                                        out_byte_next = ltr_pkg::CMD_COL_HI;
                                    end
                                    else
                                    begin
                                        out_byte_next = ltr_pkg::CMD_PAGE + {6'd0, page_reg};
                                    end
                                end
                                else
                                begin
                                    last_pend_next = tick_last;
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ltr_pkg::ST_DRAW:
            begin
                rd_vld_next = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
            end
            ltr_pkg::ST_DRAW_END:
            begin
                if (line_reg)
                begin
                    bot_next = cur_sum[8] ? 8'hFF : cur_sum[7:0];
                end
                else
                begin
                    top_next = cur_sum[8] ? 8'hFF : cur_sum[7:0];
                end
            end
            ltr_pkg::ST_TICK_DATA:
            begin
                strobe_next   = 1'b1;
                out_byte_next = fr_rd_reg;
                is_cmd_next   = 1'b0;
                last_next     = last_pend_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase

        // write back glyph bytes as they come out of the font store
        if (rd_vld_reg)
        begin
            if (rd_j_reg == '0)
            begin
                width_next = glyph_byte;
            end
            else if (int'(col) < COLUMNS)
            begin
                fr_we = 1'b1;
                fr_wa = FR_AW'(int'(wr_page) * COLUMNS + int'(col));
                fr_wd = glyph_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ltr_pkg::ST_INIT;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            page_reg   <= 2'd0;
            slot_reg   <= '0;
            top_reg    <= 8'd0;
            bot_reg    <= 8'd0;
            rd_vld_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            page_reg   <= page_next;
            slot_reg   <= slot_next;
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            rd_vld_reg <= rd_vld_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        cur_reg       <= cur_next;
        line_reg      <= line_next;
        width_reg     <= width_next;
        rd_j_reg      <= rd_j_next;
        oob_reg       <= oob_next;
        out_byte_reg  <= out_byte_next;
        is_cmd_reg    <= is_cmd_next;
        last_reg      <= last_next;
        last_pend_reg <= last_pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[font_wa] <= head.cmd.font_byte;
        end
        font_rd_reg <= font_mem[font_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            frame_mem[fr_wa] <= fr_wd;
        end
        fr_rd_reg <= frame_mem[fr_ra];
    end

    assign stat.pop    = pop;
    assign stat.init   = (state_reg == ltr_pkg::ST_INIT);
    assign strobe      = strobe_reg;
    assign out_byte    = out_byte_reg;
    assign is_command  = is_cmd_reg;
    assign frame_last  = last_reg;

endmodule

// ===== sv/lcd_text_frame_renderer.sv =====
// Top level of the LCD text frame renderer: command queue front end and execution back end.
// Commands are taken when start is high and busy is low; a two-entry queue holds them until
// the back end, which runs one command at a time, gets to them. In the back end a tick that
// yields a data byte goes through a registered read of the frame store, drawing a character
// makes one font store read per cycle and a frame clear one frame store write per cycle.
// After reset busy stays high through a pass that zeroes the frame store. Each result byte
// shows on out_byte, is_command and frame_last for a single cycle with strobe high: a command
// byte in the cycle right after its tick leaves the queue, a data byte after the ST_TICK_DATA
// state and the registered frame store read; the receiver has no way to stall it, so it must
// take every beat as it comes. Unprintable symbols, font addresses beyond the store and modes
// 5 to 7 are dropped on entry; a tick while no refresh runs is queued and then discarded by
// the back end without a beat.
module lcd_text_frame_renderer #(
    parameter int COLUMNS       = ltr_pkg::COLUMNS_DEF,
    parameter int GLYPH_BYTES   = ltr_pkg::GLYPH_BYTES_DEF,
    parameter int GLYPH_COLUMNS = ltr_pkg::GLYPH_COLUMNS_DEF,
    parameter int FONT_DEPTH    = ltr_pkg::FONT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [11:0] font_addr,
    input  logic [7:0]  font_byte,
    input  logic        text_line,
    input  logic [7:0]  symbol,
    output logic        strobe,
    output logic [7:0]  out_byte,
    output logic        is_command,
    output logic        frame_last
);

    ltr_pkg::q_head_t  head;
    ltr_pkg::bk_stat_t stat;

    ltr_front #(
        .FONT_DEPTH (FONT_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .font_addr (font_addr),
        .font_byte (font_byte),
        .text_line (text_line),
        .symbol    (symbol),
        .busy      (busy),
        .stat      (stat),
        .head      (head)
    );

    ltr_back #(
        .COLUMNS       (COLUMNS),
        .GLYPH_BYTES   (GLYPH_BYTES),
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .FONT_DEPTH    (FONT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .stat       (stat),
        .strobe     (strobe),
        .out_byte   (out_byte),
        .is_command (is_command),
        .frame_last (frame_last)
    );

endmodule

// ===== sv/ltr_chk.sv =====
// Port-level checker for the LCD text frame renderer, bound to the top level.
module ltr_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] out_byte,
    input logic       is_command,
    input logic       frame_last
);

    // the final beat of a refresh is always a display data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && frame_last |-> !is_command)
        else $error("frame_last on a command beat");

    // command beats are column low, column high or a page address
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_command |->
            (out_byte == ltr_pkg::CMD_COL_LO) || (out_byte == ltr_pkg::CMD_COL_HI)
            || (out_byte[7:2] == ltr_pkg::CMD_PAGE[7:2]))
        else $error("unexpected command byte");

    // refresh has ended, so no beat can follow straight away
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && frame_last |=> !strobe)
        else $error("beat right after the end of a refresh");

    // busy is high as reset releases, at the start of the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("not busy after reset");

endmodule

bind lcd_text_frame_renderer ltr_chk u_ltr_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .is_command (is_command),
    .frame_last (frame_last)
);

// ===== tb/sv/tb_lcd_text_frame_renderer.sv =====
// Self-checking testbench for the LCD text frame renderer: font loads, drawing and refresh streams.
`timescale 1ns / 1ps

module tb_lcd_text_frame_renderer;

    localparam int FRAME_SIZE    = ltr_pkg::PAGES * ltr_pkg::COLUMNS_DEF;
    localparam int PAGE_BEATS    = ltr_pkg::COLUMNS_DEF + ltr_pkg::CMD_SLOTS;
    localparam int REFRESH_BEATS = ltr_pkg::PAGES * PAGE_BEATS;
    localparam int GLYPH_COUNT   = ltr_pkg::LAST_SYM - ltr_pkg::FIRST_SYM + 1;
    localparam int GLYPH_AREA    = ltr_pkg::GLYPH_BYTES_DEF * GLYPH_COUNT;
    localparam int CURSOR_MAX    = 255;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [7:0] SYM_SPACE = 8'd32;
    localparam logic [7:0] SYM_A     = 8'd65;
    localparam logic [7:0] SYM_TILDE = 8'd126;
    localparam int TOTAL_ITEMS = 1000;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic [7:0] data;
        logic       command;
        logic       last;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  mode = ltr_pkg::MODE_TICK;
    logic [11:0] font_addr = '0;
    logic [7:0]  font_byte = '0;
    logic        text_line = 1'b0;
    logic [7:0]  symbol = '0;
    logic        strobe;
    logic [7:0]  out_byte;
    logic        is_command;
    logic        frame_last;

    // shadow of the block's state
    bit [7:0] frame_img [0:FRAME_SIZE-1];
    bit [7:0] font_img [0:4095];
    bit       font_known [0:4095];
    int       top_col;
    int       bot_col;
    bit       refresh_on;
    int       refresh_pos;

    beat_t pending_beats[$];
    int    errors;
    int    sent_items;
    int    calm_left;

    lcd_text_frame_renderer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .font_addr  (font_addr),
        .font_byte  (font_byte),
        .text_line  (text_line),
        .symbol     (symbol),
        .strobe     (strobe),
        .out_byte   (out_byte),
        .is_command (is_command),
        .frame_last (frame_last)
    );

    always #5 clk = ~clk;

    // Updates the shadow state for one accepted command; returns 1 unless the block drops it.
    function automatic bit apply_command(input logic [2:0] m, input logic [11:0] a,
                                         input logic [7:0] b, input logic l,
                                         input logic [7:0] s);
        int    base;
        int    cur;
        int    upper;
        int    nxt;
        int    pg;
        int    slot;
        beat_t bt;
        case (m)
            ltr_pkg::MODE_LOAD:
            begin
                font_img[a]   = b;
                font_known[a] = 1'b1;
                return 1'b1;
            end
            ltr_pkg::MODE_DRAW:
            begin
                if (s < ltr_pkg::FIRST_SYM || s > ltr_pkg::LAST_SYM)
                    return 1'b0;
                base  = ltr_pkg::GLYPH_BYTES_DEF * (s - ltr_pkg::FIRST_SYM);
                cur   = l ? bot_col : top_col;
                upper = l ? 2 : 0;
                for (int i = 0; i < ltr_pkg::GLYPH_COLUMNS_DEF; i++)
                begin
                    if (cur + i < ltr_pkg::COLUMNS_DEF)
                    begin
                        frame_img[upper * ltr_pkg::COLUMNS_DEF + cur + i] =
                            font_img[base + 2 * i + 1];
                        frame_img[(upper + 1) * ltr_pkg::COLUMNS_DEF + cur + i] =
                            font_img[base + 2 * i + 2];
                    end
                end
                nxt = cur + font_img[base];
                if (nxt > CURSOR_MAX)
                    nxt = CURSOR_MAX;
                if (l)
                    bot_col = nxt;
                else
                    top_col = nxt;
                return 1'b1;
            end
            ltr_pkg::MODE_HOME:
            begin
                top_col     = 0;
                bot_col     = 0;
                refresh_on  = 1'b1;
                refresh_pos = 0;
                return 1'b1;
            end
            ltr_pkg::MODE_CLEAR:
            begin
                for (int i = 0; i < FRAME_SIZE; i++)
                    frame_img[i] = '0;
                refresh_on  = 1'b1;
                refresh_pos = 0;
                return 1'b1;
            end
            ltr_pkg::MODE_TICK:
            begin
                if (!refresh_on)
                    return 1'b0;
                pg   = refresh_pos / PAGE_BEATS;
                slot = refresh_pos % PAGE_BEATS;
                bt.command = (slot < ltr_pkg::CMD_SLOTS);
                if (slot == 0)
                    bt.data = ltr_pkg::CMD_COL_LO;
                else if (slot == 1)
                    bt.data = ltr_pkg::CMD_COL_HI;
                else if (slot == 2)
                    bt.data = ltr_pkg::CMD_PAGE + pg[7:0];
                else
                    bt.data = frame_img[pg * ltr_pkg::COLUMNS_DEF + slot - ltr_pkg::CMD_SLOTS];
                bt.last = (refresh_pos + 1 >= REFRESH_BEATS);
                if (bt.last)
                begin
                    refresh_on  = 1'b0;
                    refresh_pos = 0;
                end
                else
                    refresh_pos++;
                pending_beats.push_back(bt);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic bit glyph_ready(input logic [7:0] s);
        int base;
        base = ltr_pkg::GLYPH_BYTES_DEF * (s - ltr_pkg::FIRST_SYM);
        for (int i = 0; i < ltr_pkg::GLYPH_BYTES_DEF; i++)
            if (!font_known[base + i])
                return 1'b0;
        return 1'b1;
    endfunction

    // mostly short gaps, a few long ones, and stretches with none at all
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high across back-to-back commands; it only drops when a gap follows
    task automatic send_cmd(input logic [2:0] m, input logic [11:0] a, input logic [7:0] b,
                            input logic l, input logic [7:0] s);
        int gap;
        mode      <= m;
        font_addr <= a;
        font_byte <= b;
        text_line <= l;
        symbol    <= s;
        start     <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        void'(apply_command(m, a, b, l, s));
        sent_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load(input int a, input logic [7:0] b);
        send_cmd(ltr_pkg::MODE_LOAD, a[11:0], b, 1'($urandom), 8'($urandom));
    endtask

    task automatic draw(input logic l, input logic [7:0] s);
        send_cmd(ltr_pkg::MODE_DRAW, 12'($urandom), 8'($urandom), l, s);
    endtask

    task automatic plain(input logic [2:0] m);
        send_cmd(m, 12'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic load_glyph(input logic [7:0] s, input logic [7:0] width, input int fill);
        int base;
        base = ltr_pkg::GLYPH_BYTES_DEF * (s - ltr_pkg::FIRST_SYM);
        load(base, width);
        for (int i = 1; i < ltr_pkg::GLYPH_BYTES_DEF; i++)
            load(base + i, (fill < 0) ? 8'($urandom) : fill[7:0]);
    endtask

    function automatic logic [7:0] pick_symbol();
        int r;
        logic [7:0] s;
        if ($urandom_range(0, 9) == 0)
        begin
            r = $urandom_range(0, 160);
            return (r < 32) ? r[7:0] : 8'(r + 95);
        end
        s = 8'($urandom_range(ltr_pkg::FIRST_SYM, ltr_pkg::LAST_SYM));
        while (!glyph_ready(s))
            s = 8'($urandom_range(ltr_pkg::FIRST_SYM, ltr_pkg::LAST_SYM));
        return s;
    endfunction

    task automatic test_font_load();
        load_glyph(SYM_SPACE, 8'd0, 8'hFF);
        load_glyph(SYM_TILDE, 8'd255, 8'h00);
        load_glyph(SYM_A, 8'(ltr_pkg::GLYPH_COLUMNS_DEF), -1);
        load(4095, 8'hFF);
        load(GLYPH_AREA, 8'h00);
    endtask

    task automatic test_ignored_items();
        plain(ltr_pkg::MODE_TICK);
        for (logic [2:0] m = MODE_SPARE_LO; m <= MODE_SPARE_HI && m >= MODE_SPARE_LO; m++)
            plain(m);
        draw(1'b0, 8'd0);
        draw(1'b1, 8'd31);
        draw(1'b0, 8'd127);
        draw(1'b1, 8'd255);
    endtask

    task automatic test_draw_edges();
        // eleven A glyphs run the top line into the right edge, the last one keeping 8 of its 12 columns
        for (int i = 0; i < 11; i++)
            draw(1'b0, SYM_A);
        draw(1'b0, SYM_A);
        draw(1'b0, SYM_SPACE);
        // wide glyph pushes the bottom cursor to its ceiling, then holds it there
        draw(1'b1, SYM_TILDE);
        draw(1'b1, SYM_TILDE);
        draw(1'b1, SYM_A);
    endtask

    task automatic test_refresh_stream();
        plain(ltr_pkg::MODE_CLEAR);
        draw(1'b0, SYM_A);
        draw(1'b1, SYM_A);
        for (int i = 0; i < 60; i++)
            plain(ltr_pkg::MODE_TICK);
        draw(1'b0, SYM_SPACE);
        draw(1'b1, SYM_A);
        plain(ltr_pkg::MODE_HOME);
        for (int i = 0; i < REFRESH_BEATS; i++)
        begin
            if (i == 300)
                draw(1'b1, SYM_A);
            plain(ltr_pkg::MODE_TICK);
        end
        plain(ltr_pkg::MODE_TICK);
        plain(ltr_pkg::MODE_TICK);
    endtask

    task automatic test_random_traffic();
        int r;
        int n;
        while (sent_items < TOTAL_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                n = $urandom_range(0, 19);
                load_glyph(8'($urandom_range(ltr_pkg::FIRST_SYM, ltr_pkg::LAST_SYM)),
                           (n == 0) ? 8'd0 : (n == 1) ? 8'd255 : 8'($urandom_range(1, 14)), -1);
            end
            else if (r < 40)
            begin
                n = $urandom_range(2, 10);
                for (int i = 0; i < n; i++)
                    draw(1'($urandom), pick_symbol());
            end
            else if (r < 46)
                plain(ltr_pkg::MODE_HOME);
            else if (r < 48)
                plain(ltr_pkg::MODE_CLEAR);
            else if (r < 49)
            begin
                plain(ltr_pkg::MODE_HOME);
                for (int i = 0; i < REFRESH_BEATS + 2; i++)
                    plain(ltr_pkg::MODE_TICK);
            end
            else if (r < 90)
            begin
                n = $urandom_range(5, 60);
                for (int i = 0; i < n; i++)
                    plain(ltr_pkg::MODE_TICK);
            end
            else
            begin
                n = $urandom_range(0, 3);
                if (n == 0)
                    plain(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
                else if (n == 1)
                    load($urandom_range(GLYPH_AREA, 4095), 8'($urandom));
                else if (n == 2)
                    draw(1'($urandom), 8'($urandom_range(0, 31)));
                else
                    plain(ltr_pkg::MODE_TICK);
            end
        end
    endtask

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, got byte %02h cmd %0b last %0b",
                         $time, out_byte, is_command, frame_last);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte: expected %02h, got %02h", $time, want.data,
                             out_byte);
                    errors++;
                end
                if (is_command !== want.command)
                begin
                    $display("%0t: is_command: expected %0b, got %0b", $time, want.command,
                             is_command);
                    errors++;
                end
                if (frame_last !== want.last)
                begin
                    $display("%0t: frame_last: expected %0b, got %0b", $time, want.last,
                             frame_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("** lcd_text_frame_renderer: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_font_load();
        test_ignored_items();
        test_draw_edges();
        test_refresh_stream();
        test_random_traffic();
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        // a clear may still be running, and a stray beat must not slip past
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** lcd_text_frame_renderer: PASSED **");
        else
            $display("** lcd_text_frame_renderer: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ltr_pkg.sv
sv/ltr_front.sv
sv/ltr_back.sv
sv/lcd_text_frame_renderer.sv
sv/ltr_chk.sv
tb/sv/tb_lcd_text_frame_renderer.sv
